/* hw/rtl/wsp_pkg.sv */
// wsp_pkg: item types, parser phases, value kind codes and octet class
// functions for the WSP header stream parser. No dependencies.
package wsp_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic        at_end;
    logic        header_kind;
    logic [7:0]  field_code;
    logic [15:0] name_offset;
    logic [1:0]  value_kind;
    logic [15:0] value_offset;
    logic [15:0] value_length;
    logic [7:0]  short_value;
    logic [7:0]  page_num;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HDR,
    PH_PAGE,
    PH_NAME,
    PH_VSTART,
    PH_UVAR,
    PH_BODY,
    PH_TEXT
  } phase_t;

  localparam logic [1:0] VK_SHORT = 2'd0;
  localparam logic [1:0] VK_LONG  = 2'd1;
  localparam logic [1:0] VK_TEXT  = 2'd2;

  localparam logic [7:0] OCT_SHIFT  = 8'd127;
  localparam logic [7:0] OCT_UINTVAR = 8'd31;
  localparam logic [7:0] OCT_LEN_MAX = 8'd30;

  localparam int UV_DIGITS = 5;
  localparam int UV_W      = 7 * UV_DIGITS;

  // Control octets other than zero and tab
  function automatic logic is_ctl(input logic [7:0] b);
    return (b >= 8'd1 && b <= 8'd8) || (b >= 8'd10 && b <= 8'd31) || b == 8'd127;
  endfunction

  // Token separators, space and tab included
  function automatic logic is_sep(input logic [7:0] b);
    return b inside {8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A,
                     8'h5C, 8'h22, 8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B,
                     8'h7D, 8'h20, 8'h09};
  endfunction

endpackage

/* hw/rtl/wsp_header_stream_parser.sv */
// wsp_header_stream_parser: byte-serial WSP header PDU decoder with a
// two-entry result buffer. Depends on wsp_pkg.
// A result is registered into the output register, or the skid slot if it is full.
// Throughput: one octet per cycle; input stalls only when both result slots are full.
// Reset (synchronous, rst high): parser at header start of a new PDU,
// offset 0, code page 1, shift rejection off, result buffer empty.
module wsp_header_stream_parser import wsp_pkg::*; #(
  parameter longint unsigned MAX_PDU_BYTES = 65535
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  // Offsets never pass MAX_PDU_BYTES, so they need only this many bits
  localparam int POS_W = $clog2(MAX_PDU_BYTES + 1);
  localparam int SUM_W = UV_W + 1;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_PDU_BYTES);
  localparam logic [SUM_W-1:0] MAX_SUM = SUM_W'(MAX_PDU_BYTES);

  // Configuration
  logic reject_shift;

  // Parser state
  phase_t           phase;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       page_in_force;
  logic [POS_W-1:0] name_start;
  logic             name_is_text;
  logic [7:0]       field_octet;
  logic [POS_W-1:0] value_start;
  logic [1:0]       value_type_held;
  logic [POS_W-1:0] bytes_left;
  logic [UV_W-1:0]  length_accumulator;
  logic [2:0]       length_digit_count;
  logic             failed;

  // Next values
  phase_t           phase_next;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       page_in_force_next;
  logic [POS_W-1:0] name_start_next;
  logic             name_is_text_next;
  logic [7:0]       field_octet_next;
  logic [POS_W-1:0] value_start_next;
  logic [1:0]       value_type_held_next;
  logic [POS_W-1:0] bytes_left_next;
  logic [UV_W-1:0]  length_accumulator_next;
  logic [2:0]       length_digit_count_next;
  logic             failed_next;

  // State after this octet's step, before end-of-header handling
  phase_t           u_phase;
  logic [7:0]       u_page;
  logic [POS_W-1:0] u_name_start;
  logic             u_text;
  logic [7:0]       u_field;
  logic [POS_W-1:0] u_vstart;
  logic [1:0]       u_vtype;
  logic [POS_W-1:0] u_left;
  logic [UV_W-1:0]  u_acc;
  logic [2:0]       u_cnt;

  logic [7:0]       b;
  logic             last;
  logic             in_fire;
  logic             hdr_ok;
  logic             hdr_err;
  logic [POS_W-1:0] vlen;
  logic [7:0]       sval;
  logic             long_go;
  logic [UV_W-1:0]  long_len;
  logic [SUM_W-1:0] long_sum;
  logic [UV_W-1:0]  acc_new;
  logic [2:0]       cnt_new;
  logic [POS_W-1:0] left_dec;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] vlen_run;
  logic             new_pdu;
  logic             emit;
  out_item_t        result;

  // Two-entry result buffer
  logic      skid_valid;
  out_item_t skid_data;
  logic      pop;

  assign b         = in_data.data_byte;
  assign last      = in_data.last_byte;
  assign in_ready  = !skid_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign pop       = out_valid && out_ready;

  assign acc_new  = {length_accumulator[UV_W-8:0], b[6:0]};
  assign cnt_new  = length_digit_count + 3'd1;
  assign left_dec = bytes_left - POS_W'(1);
  assign pos_inc  = byte_position + POS_W'(1);
  assign vlen_run = pos_inc - value_start;

  // One octet step
  always_comb begin
    u_phase      = phase;
    u_page       = page_in_force;
    u_name_start = name_start;
    u_text       = name_is_text;
    u_field      = field_octet;
    u_vstart     = value_start;
    u_vtype      = value_type_held;
    u_left       = bytes_left;
    u_acc        = length_accumulator;
    u_cnt        = length_digit_count;
    hdr_ok       = 1'b0;
    hdr_err      = 1'b0;
    vlen         = '0;
    sval         = '0;
    long_go      = 1'b0;
    long_len     = '0;

    if (byte_position >= MAX_POS) begin
      hdr_err = 1'b1;
    end else begin
      case (phase)
        PH_HDR: begin
          if (b == OCT_SHIFT || (b >= 8'd1 && b <= 8'd31)) begin
            // code page shift, either escape form or short-cut
            if (reject_shift || last) begin
              hdr_err = 1'b1;
            end else if (b == OCT_SHIFT) begin
              u_phase = PH_PAGE;
            end else begin
              u_page = b;
            end
          end else begin
            u_name_start = byte_position;
            if (b[7]) begin
              u_text  = 1'b0;
              u_field = b;
              if (last) hdr_err = 1'b1;
              else      u_phase = PH_VSTART;
            end else begin
              u_text  = 1'b1;
              u_field = '0;
              if (last) begin
                hdr_err = 1'b1;
              end else if (b == 8'd0) begin
                u_phase = PH_VSTART;  // empty token name
              end else if (is_sep(b)) begin
                hdr_err = 1'b1;
              end else begin
                u_phase = PH_NAME;
              end
            end
          end
        end
        PH_PAGE: begin
          if (last) begin
            hdr_err = 1'b1;
          end else begin
            u_page  = b;
            u_phase = PH_HDR;
          end
        end
        PH_NAME: begin
          if (last) hdr_err = 1'b1;
          else if (b == 8'd0) u_phase = PH_VSTART;
          else if (is_ctl(b) || is_sep(b)) hdr_err = 1'b1;
        end
        PH_VSTART: begin
          if (name_is_text && (b < 8'd32 || b > 8'd127)) begin
            hdr_err = 1'b1;
          end else if (b <= OCT_LEN_MAX) begin
            long_go  = 1'b1;
            long_len = UV_W'(b);
          end else if (b[7]) begin
            u_vtype  = VK_SHORT;
            u_vstart = byte_position;
            hdr_ok   = 1'b1;
            vlen     = POS_W'(1);
            sval     = b;
          end else if (b == OCT_UINTVAR) begin
            if (last) begin
              hdr_err = 1'b1;
            end else begin
              u_acc   = '0;
              u_cnt   = '0;
              u_phase = PH_UVAR;
            end
          end else if (is_ctl(b) || last) begin
            hdr_err = 1'b1;
          end else begin
            u_vtype  = VK_TEXT;
            u_vstart = byte_position;
            u_phase  = PH_TEXT;
          end
        end
        PH_UVAR: begin
          u_acc = acc_new;
          u_cnt = cnt_new;
          if (b[7]) begin
            if (cnt_new >= 3'(UV_DIGITS) || last) hdr_err = 1'b1;
          end else begin
            long_go  = 1'b1;
            long_len = acc_new;
          end
        end
        PH_BODY: begin
          u_left = left_dec;
          if (left_dec == '0) begin
            hdr_ok = 1'b1;
            vlen   = vlen_run;
          end else if (last) begin
            hdr_err = 1'b1;
          end
        end
        PH_TEXT: begin
          if (b == 8'd0) begin
            hdr_ok = 1'b1;
            vlen   = vlen_run;
          end else if (is_ctl(b) || last) begin
            hdr_err = 1'b1;
          end
        end
        default: hdr_err = 1'b1;
      endcase
    end

    // Long value with a known length: check the end, then complete or wait
    long_sum = SUM_W'(pos_inc) + SUM_W'(long_len);
    if (long_go) begin
      u_vtype  = VK_LONG;
      u_vstart = pos_inc;
      if (long_sum > MAX_SUM) begin
        hdr_err = 1'b1;
      end else if (long_len == '0) begin
        hdr_ok = 1'b1;
        vlen   = '0;
      end else if (last) begin
        hdr_err = 1'b1;
      end else begin
        u_left  = long_len[POS_W-1:0];
        u_phase = PH_BODY;
      end
    end
  end

  // Result item
  always_comb begin
    result = '0;
    if (hdr_err) begin
      result.status = 1'b1;
    end else begin
      result.status       = 1'b0;
      result.at_end       = last;
      result.header_kind  = u_text;
      result.field_code   = u_text ? 8'd0 : u_field;
      result.name_offset  = 16'(u_name_start);
      result.value_kind   = u_vtype;
      result.value_offset = 16'(u_vstart);
      result.value_length = 16'(vlen);
      result.short_value  = sval;
      result.page_num     = u_page;
    end
  end

  assign emit = in_fire && !failed && (hdr_ok || hdr_err);

  // Register next values; a marked last octet always starts a new PDU
  always_comb begin
    phase_next              = phase;
    byte_position_next      = byte_position;
    page_in_force_next      = page_in_force;
    name_start_next         = name_start;
    name_is_text_next       = name_is_text;
    field_octet_next        = field_octet;
    value_start_next        = value_start;
    value_type_held_next    = value_type_held;
    bytes_left_next         = bytes_left;
    length_accumulator_next = length_accumulator;
    length_digit_count_next = length_digit_count;
    failed_next             = failed;
    new_pdu                 = 1'b0;

    if (in_fire) begin
      if (failed || hdr_err) begin
        // skip the rest of a malformed PDU
        if (last) new_pdu = 1'b1;
        else      failed_next = 1'b1;
      end else if (hdr_ok && last) begin
        new_pdu = 1'b1;
      end else begin
        phase_next              = hdr_ok ? PH_HDR : u_phase;
        byte_position_next      = pos_inc;
        page_in_force_next      = u_page;
        name_start_next         = u_name_start;
        name_is_text_next       = u_text;
        field_octet_next        = u_field;
        value_start_next        = u_vstart;
        value_type_held_next    = u_vtype;
        bytes_left_next         = u_left;
        length_accumulator_next = u_acc;
        length_digit_count_next = u_cnt;
      end
    end

    if (new_pdu) begin
      phase_next              = PH_HDR;
      byte_position_next      = '0;
      page_in_force_next      = 8'd1;
      name_start_next         = '0;
      name_is_text_next       = 1'b0;
      field_octet_next        = '0;
      value_start_next        = '0;
      value_type_held_next    = '0;
      bytes_left_next         = '0;
      length_accumulator_next = '0;
      length_digit_count_next = '0;
      failed_next             = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reject_shift       <= 1'b0;
      phase              <= PH_HDR;
      byte_position      <= '0;
      page_in_force      <= 8'd1;
      name_start         <= '0;
      name_is_text       <= 1'b0;
      field_octet        <= '0;
      value_start        <= '0;
      value_type_held    <= '0;
      bytes_left         <= '0;
      length_accumulator <= '0;
      length_digit_count <= '0;
      failed             <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) reject_shift <= cfg_data;
      phase              <= phase_next;
      byte_position      <= byte_position_next;
      page_in_force      <= page_in_force_next;
      name_start         <= name_start_next;
      name_is_text       <= name_is_text_next;
      field_octet        <= field_octet_next;
      value_start        <= value_start_next;
      value_type_held    <= value_type_held_next;
      bytes_left         <= bytes_left_next;
      length_accumulator <= length_accumulator_next;
      length_digit_count <= length_digit_count_next;
      failed             <= failed_next;
    end
  end

  // Result buffer: output register plus one skid slot. in_ready drops only
  // while the skid slot holds an item, so no push can meet a full buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (emit) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (emit) begin
      if (out_valid && !pop) skid_data <= result;
      else                   out_data  <= result;
    end
  end

endmodule

/* bench/tb_wsp_header_stream_parser.sv */
// Self-checking bench for wsp_header_stream_parser: random and directed header PDUs,
// an in-bench header decoder that predicts every result, and random stalls on both sides.
// Depends on wsp_pkg and the parser RTL only.
`timescale 1ns / 1ps

module tb_wsp_header_stream_parser;
  import wsp_pkg::*;

  localparam longint unsigned PDU_LIMIT = 65535;
  localparam int WATCHDOG_CYCLES = 2000;
  localparam int SETTLE_CYCLES   = 4;   // results leave the parser through registers

  logic      clk;
  logic      rst;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  wsp_header_stream_parser #(.MAX_PDU_BYTES(PDU_LIMIT)) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Header decoder: the bench's own copy of the parser state, advanced once per
  // accepted octet. Every result it produces is queued in decoded_q.
  // ---------------------------------------------------------------------------
  phase_t          ph;
  int unsigned     pos;          // offset of the next octet within the PDU
  logic [7:0]      page;
  int unsigned     name_at;
  bit              name_txt;
  logic [7:0]      fcode;
  int unsigned     val_at;
  logic [1:0]      vkind;
  longint unsigned remain;       // body octets still to come
  logic [34:0]     uv_acc;
  int              uv_digits;
  bit              dead;         // PDU already reported malformed
  bit              reject_shift = 1'b0;

  out_item_t decoded_q[$];
  in_item_t  octet_q[$];         // octets waiting for the driver
  logic [7:0] frame[$];          // PDU under construction

  int errors       = 0;
  int octets_sent  = 0;
  int headers_seen = 0;
  int faults_seen  = 0;
  bit steady       = 1'b0;       // no idling on either side while set

  function automatic bit is_control(logic [7:0] b);
    return (b != 8'd0 && b < 8'd32 && b != 8'd9) || b == 8'd127;
  endfunction

  function automatic bit is_token_sep(logic [7:0] b);
    case (b)
      "(", ")", "<", ">", "@", ",", ";", ":", "\\", "\"", "/", "[", "]", "?", "=",
      "{", "}", " ", 8'd9: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  task automatic restart_pdu();
    ph        = PH_HDR;
    pos       = 0;
    page      = 8'd1;
    name_at   = 0;
    name_txt  = 1'b0;
    fcode     = 8'd0;
    val_at    = 0;
    vkind     = VK_SHORT;
    remain    = 0;
    uv_acc    = '0;
    uv_digits = 0;
    dead      = 1'b0;
  endtask

  // Malformed PDU: a bare status bit; the rest of the PDU is then skipped.
  task automatic report_fault(bit last);
    out_item_t r;
    r = '0;
    r.status = 1'b1;
    decoded_q.push_back(r);
    if (last) restart_pdu();
    else dead = 1'b1;
  endtask

  task automatic report_header(bit last, int unsigned vlen, logic [7:0] sval);
    out_item_t r;
    r.status       = 1'b0;
    r.at_end       = last;
    r.header_kind  = name_txt;
    r.field_code   = name_txt ? 8'd0 : fcode;
    r.name_offset  = name_at[15:0];
    r.value_kind   = vkind;
    r.value_offset = val_at[15:0];
    r.value_length = vlen[15:0];
    r.short_value  = sval;
    r.page_num     = page;
    decoded_q.push_back(r);
    if (last) restart_pdu();
    else begin
      ph = PH_HDR;
      pos++;
    end
  endtask

  // Long value whose length is now known: done if empty, else wait for the body.
  task automatic open_long_value(longint unsigned len, int unsigned p, bit last);
    vkind  = VK_LONG;
    val_at = p + 1;
    if (val_at + len > PDU_LIMIT) report_fault(last);
    else if (len == 0) report_header(last, 0, 8'd0);
    else if (last) report_fault(last);
    else begin
      remain = len;
      ph     = PH_BODY;
      pos++;
    end
  endtask

  task automatic decode_octet(in_item_t it);
    logic [7:0]  b;
    bit          last;
    int unsigned p;
    b    = it.data_byte;
    last = it.last_byte;
    p    = pos;
    if (dead) begin
      if (last) restart_pdu();
      return;
    end
    if (p >= PDU_LIMIT) begin
      report_fault(last);
      return;
    end
    case (ph)
      PH_HDR: begin
        if (b == OCT_SHIFT || (b >= 8'd1 && b <= 8'd31)) begin
          // shift sequence: long form takes a page octet, short-cut is the page
          if (reject_shift || last) begin
            report_fault(last);
            return;
          end
          if (b == OCT_SHIFT) ph = PH_PAGE;
          else page = b;
        end else begin
          name_at  = p;
          name_txt = (b < 8'h80);
          fcode    = name_txt ? 8'd0 : b;
          if (last || (name_txt && b != 8'd0 && is_token_sep(b))) begin
            report_fault(last);
            return;
          end
          ph = (!name_txt || b == 8'd0) ? PH_VSTART : PH_NAME;
        end
      end
      PH_PAGE: begin
        if (last) begin
          report_fault(last);
          return;
        end
        page = b;
        ph   = PH_HDR;
      end
      PH_NAME: begin
        if (last) begin
          report_fault(last);
          return;
        end
        if (b == 8'd0) ph = PH_VSTART;
        else if (is_control(b) || is_token_sep(b)) begin
          report_fault(last);
          return;
        end
      end
      PH_VSTART: begin
        if (name_txt && (b < 8'd32 || b > 8'd127)) begin
          report_fault(last);
          return;
        end
        if (b <= OCT_LEN_MAX) begin
          open_long_value(b, p, last);
          return;
        end
        if (b >= 8'd128) begin
          vkind  = VK_SHORT;
          val_at = p;
          report_header(last, 1, b);
          return;
        end
        if (b == OCT_UINTVAR) begin
          if (last) begin
            report_fault(last);
            return;
          end
          uv_acc    = '0;
          uv_digits = 0;
          ph        = PH_UVAR;
        end else if (is_control(b) || last) begin
          report_fault(last);
          return;
        end else begin
          vkind  = VK_TEXT;
          val_at = p;
          ph     = PH_TEXT;
        end
      end
      PH_UVAR: begin
        uv_acc = {uv_acc[27:0], b[6:0]};
        uv_digits++;
        if (!b[7]) begin
          open_long_value(uv_acc, p, last);
          return;
        end
        if (uv_digits >= UV_DIGITS || last) begin
          report_fault(last);
          return;
        end
      end
      PH_BODY: begin
        remain--;
        if (remain == 0) begin
          report_header(last, p + 1 - val_at, 8'd0);
          return;
        end
        if (last) begin
          report_fault(last);
          return;
        end
      end
      PH_TEXT: begin
        if (b == 8'd0) begin
          report_header(last, p + 1 - val_at, 8'd0);
          return;
        end
        if (is_control(b) || last) begin
          report_fault(last);
          return;
        end
      end
      default: begin
        report_fault(last);
        return;
      end
    endcase
    pos++;
  endtask

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then a long one.
  // ---------------------------------------------------------------------------
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: loads the next octet once the current one is taken, then idles.
  int gap       = 0;
  bit src_burst = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        decode_octet(in_data);
        octets_sent++;
      end
      if (!in_valid || in_ready) begin
        if (gap > 0) begin
          gap--;
          in_valid <= 1'b0;
        end else if (octet_q.size() != 0) begin
          in_data  <= octet_q.pop_front();
          in_valid <= 1'b1;
          if ($urandom_range(0, 63) == 0) src_burst = !src_burst;
          gap = (steady || src_burst) ? 0 : idle_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure, each result checked against the oldest prediction.
  int        hold       = 0;
  bit        sink_burst = 1'b0;
  out_item_t want;

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, exp_v, got_v);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got %p", $time, out_data);
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (want.status) faults_seen++;
          else headers_seen++;
          check_field("status",       want.status,       out_data.status);
          check_field("at_end",       want.at_end,       out_data.at_end);
          check_field("header_kind",  want.header_kind,  out_data.header_kind);
          check_field("field_code",   want.field_code,   out_data.field_code);
          check_field("name_offset",  want.name_offset,  out_data.name_offset);
          check_field("value_kind",   want.value_kind,   out_data.value_kind);
          check_field("value_offset", want.value_offset, out_data.value_offset);
          check_field("value_length", want.value_length, out_data.value_length);
          check_field("short_value",  want.short_value,  out_data.short_value);
          check_field("page_num",     want.page_num,     out_data.page_num);
        end
      end
      if ($urandom_range(0, 63) == 0) sink_burst = !sink_burst;
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!steady && !sink_burst && $urandom_range(0, 3) == 0) begin
        hold = idle_len();
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WATCHDOG_CYCLES) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("wsp_header_stream_parser verification failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus building blocks
  // ---------------------------------------------------------------------------
  task automatic send_frame();
    in_item_t it;
    for (int i = 0; i < frame.size(); i++) begin
      it.data_byte = frame[i];
      it.last_byte = (i == frame.size() - 1);
      octet_q.push_back(it);
    end
  endtask

  // Sender holds off until every predicted result is in, then lets the block settle.
  task automatic wait_drained();
    while (octet_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reject(bit v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reject_shift = v;
  endtask

  // Uintvar, big-endian 7-bit groups, optionally padded with empty leading groups.
  task automatic add_uintvar(int unsigned v, int pad);
    logic [7:0] grp[$];
    do begin
      grp.push_front(8'(v & 32'h7F));
      v = v >> 7;
    end while (v != 0);
    repeat (pad) grp.push_front(8'h00);
    for (int i = 0; i < grp.size(); i++)
      frame.push_back(i == grp.size() - 1 ? grp[i] : (grp[i] | 8'h80));
  endtask

  function automatic logic [7:0] token_char();
    logic [7:0] b;
    do b = 8'($urandom_range(33, 126)); while (is_token_sep(b));
    return b;
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd9;
    if (r < 4) return 8'($urandom_range(32, 126));
    return 8'($urandom_range(128, 255));
  endfunction

  task automatic add_text();
    int n;
    frame.push_back(8'($urandom_range(32, 126)));
    n = $urandom_range(0, 5);
    repeat (n) frame.push_back(text_char());
    frame.push_back(8'h00);
  endtask

  // One well-formed header, with an occasional code page shift in front.
  task automatic add_header();
    int pick;
    int len;
    pick = $urandom_range(0, 9);
    if (pick < 2) frame = {frame, OCT_SHIFT, 8'($urandom_range(0, 255))};
    else if (pick < 3) frame.push_back(8'($urandom_range(1, 31)));
    pick = $urandom_range(0, 19);
    if (pick < 10) begin
      frame.push_back(8'($urandom_range(128, 255)));
      case ($urandom_range(0, 3))
        0: frame.push_back(8'($urandom_range(128, 255)));
        1: begin
          len = $urandom_range(0, 30);
          frame.push_back(8'(len));
          repeat (len) frame.push_back(8'($urandom));
        end
        2: begin
          len = $urandom_range(0, 40);
          frame.push_back(OCT_UINTVAR);
          add_uintvar(len, $urandom_range(0, 2));
          repeat (len) frame.push_back(8'($urandom));
        end
        default: add_text();
      endcase
    end else begin
      // token text name; empty name now and then
      if (pick < 17) repeat ($urandom_range(1, 6)) frame.push_back(token_char());
      frame.push_back(8'h00);
      add_text();
    end
  endtask

  // Headers that probe the error paths and the uintvar digit limit.
  task automatic add_odd_header();
    case ($urandom_range(0, 5))
      0: frame = {frame, 8'h80, OCT_UINTVAR, 8'h81, 8'h81, 8'h81, 8'h81, 8'h81, 8'h01};
      1: frame = {frame, 8'h80, OCT_UINTVAR, 8'h84, 8'h80, 8'h00};  // length past the PDU limit
      2: frame = {frame, 8'h80, 8'h61, 8'h05, 8'h00};               // control octet in text
      3: frame = {frame, 8'h61, 8'h3D, 8'h00};                      // separator inside a name
      4: frame = {frame, 8'h61, 8'h00, 8'h80};                      // token name, short value
      default: frame = {frame, 8'h80, OCT_UINTVAR, 8'h80, 8'h80, 8'h80, 8'h80, 8'h02,
                        8'h33, 8'h44};                              // five-digit uintvar
    endcase
  endtask

  // Mostly well-formed PDUs; some cut short, corrupted, odd, or pure noise.
  task automatic random_run(int target);
    int sent;
    int pick;
    int n;
    sent = 0;
    while (sent < target) begin
      frame.delete();
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        n = $urandom_range(1, 8);
        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) add_header();
        if (pick < 15) begin
          n = $urandom_range(0, frame.size() - 1);
          frame = frame[0:n];
        end else if (pick < 25) begin
          n = $urandom_range(0, frame.size() - 1);
          frame[n] = 8'($urandom_range(0, 255));
        end else if (pick < 30) begin
          add_odd_header();
          if ($urandom_range(0, 1) == 0) add_header();
        end
      end
      sent += frame.size();
      send_frame();
      if ($urandom_range(0, 39) == 0) wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    restart_pdu();
    @(posedge clk);

    write_reject(1'b0);

    // long shift to page 255 with the largest name and short value
    frame = {OCT_SHIFT, 8'hFF, 8'hFF, 8'hFF};
    send_frame();
    // short-cut shift, empty long value on the last octet
    frame = {8'h1F, 8'h80, 8'h00};
    send_frame();
    // empty token name with a one-character text value
    frame = {8'h00, 8'h61, 8'h00};
    send_frame();
    // token name and text, then a padded uintvar long value
    frame = {8'h58, 8'h00, 8'h76, 8'h00, 8'h81, OCT_UINTVAR, 8'h80, 8'h02, 8'hAA, 8'h55};
    send_frame();
    // separator at header start; the trailing octet is skipped
    frame = {8'h28, 8'h41};
    send_frame();
    // long value cut short by the last octet
    frame = {8'h85, 8'h03, 8'h01};
    send_frame();
    wait_drained();

    random_run(300);
    wait_drained();

    // every shift is now a fault
    write_reject(1'b1);
    frame = {8'h05, 8'h80, 8'h81};
    send_frame();
    random_run(250);
    wait_drained();

    // uintvar length whose value would end one past the PDU limit
    write_reject(1'b0);
    steady = 1'b1;
    frame = {8'h80, OCT_UINTVAR};
    add_uintvar(32'(PDU_LIMIT - 4), 0);
    frame = {frame, 8'h11, 8'h22};
    send_frame();
    wait_drained();
    steady = 1'b0;

    random_run(350);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d octets; checked %0d headers and %0d malformed-PDU reports,", octets_sent,
             headers_seen, faults_seen);
    $display("with shift rejection off and on and a value length past the PDU limit.");
    if (errors == 0) begin
      $display("wsp_header_stream_parser verification clean");
    end else begin
      $display("wsp_header_stream_parser verification failed");
    end
    $finish;
  end

endmodule
